// File: rtl/core/iir4_pkg.sv
// Package for the fourth-order IIR filter: defaults, register indexes,
// the sequencer phase type and the control struct sent to the datapath cells.
// No dependencies.
package iir4_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 24;
  localparam int ACCUM_WIDTH_DEF  = 48;

  localparam int NUM_SECTIONS   = 4;
  localparam int NUM_COEFS      = 9;
  localparam int NUM_PAIRS      = 4;
  localparam int CFG_ADDR_WIDTH = 6;
  localparam int CFG_DATA_WIDTH = 64;
  localparam int CFG_IDX_LSB    = 3;

  typedef enum logic [2:0] {
    REG_B0_B1 = 3'd0,
    REG_B2_B3 = 3'd1,
    REG_B4_A1 = 3'd2,
    REG_A2_A3 = 3'd3,
    REG_A4    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL_BX,
    PH_CALC_Y,
    PH_MUL_LO,
    PH_MUL_HI,
    PH_MERGE,
    PH_ROUND,
    PH_UPDATE
  } phase_t;

  typedef struct packed {
    logic mul_bx;
    logic calc_y;
    logic mul_lo;
    logic mul_hi;
    logic merge;
    logic round;
    logic update;
  } ctrl_t;

endpackage

// File: rtl/core/iir4_head.sv
// Head of the filter: forms y = b0*x + s0 with saturation and the rounded,
// saturated output sample. Depends on iir4_pkg.
module iir4_head #(
  parameter int SAMPLE_WIDTH = iir4_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = iir4_pkg::COEF_WIDTH_DEF,
  parameter int ACCUM_WIDTH  = iir4_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  iir4_pkg::ctrl_t                ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [COEF_WIDTH-1:0]   coef_b0,
  input  logic signed [ACCUM_WIDTH-1:0]  s0,
  output logic signed [ACCUM_WIDTH-1:0]  y,
  output logic                           y_clip,
  output logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           sample_clip
);

  localparam int S    = SAMPLE_WIDTH;
  localparam int C    = COEF_WIDTH;
  localparam int A    = ACCUM_WIDTH;
  localparam int F    = C - 4;
  localparam int PW   = C + S;
  localparam int YW   = ((PW > A) ? PW : A) + 1;
  localparam int RX   = A + S + 1;
  localparam logic signed [RX-1:0] HALF = RX'(1) << (F - 1);

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [YW-1:0] ysum;
  logic                 yfit;
  logic signed [A-1:0]  y_r;
  logic signed [A-1:0]  y_nxt;
  logic                 yclip_r;
  logic signed [RX-1:0] yx;
  logic signed [RX-1:0] yq;
  logic                 qfit;

  assign prod_nxt = coef_b0 * x;

  // exact sum, then one saturation to the accumulator width
  assign ysum  = YW'(prod_r) + YW'(s0);
  assign yfit  = (&ysum[YW-1:A-1]) || (~|ysum[YW-1:A-1]);
  assign y_nxt = yfit ? ysum[A-1:0] : {ysum[YW-1], {(A-1){~ysum[YW-1]}}};

  always_ff @(posedge clk) begin
    if (ctrl.mul_bx) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.calc_y) begin
      y_r     <= y_nxt;
      yclip_r <= ~yfit;
    end
  end

  // round half up to an integer, then saturate to the sample width
  assign yx     = RX'(y_r) + HALF;
  assign yq     = yx >>> F;
  assign qfit   = (&yq[RX-1:S-1]) || (~|yq[RX-1:S-1]);
  assign sample = qfit ? yq[S-1:0] : {yq[RX-1], {(S-1){~yq[RX-1]}}};

  assign sample_clip = ~qfit;
  assign y           = y_r;
  assign y_clip      = yclip_r;

endmodule

// File: rtl/core/iir4_cell.sv
// One section of the transposed form: holds one accumulator and computes
// s = s_next + b*x - round(a*y) on a shared multiplier. Depends on iir4_pkg.
module iir4_cell #(
  parameter int SAMPLE_WIDTH = iir4_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = iir4_pkg::COEF_WIDTH_DEF,
  parameter int ACCUM_WIDTH  = iir4_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  iir4_pkg::ctrl_t                ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [ACCUM_WIDTH-1:0]  y,
  input  logic signed [COEF_WIDTH-1:0]   coef_b,
  input  logic signed [COEF_WIDTH-1:0]   coef_a,
  input  logic signed [ACCUM_WIDTH-1:0]  s_next,
  output logic signed [ACCUM_WIDTH-1:0]  s,
  output logic                           clip
);

  localparam int S   = SAMPLE_WIDTH;
  localparam int C   = COEF_WIDTH;
  localparam int A   = ACCUM_WIDTH;
  localparam int F   = C - 4;
  localparam int H   = A / 2;
  localparam int MB0 = (S > H + 1) ? S : H + 1;
  localparam int MB  = (MB0 > A - H) ? MB0 : A - H;
  localparam int MW  = C + MB;
  localparam int AW  = C + A;
  localparam int QW  = AW - F;
  localparam int TW  = ((C + S > QW) ? C + S : QW) + 2;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (F - 1);

  logic signed [C-1:0]     op_a;
  logic signed [MB-1:0]    op_b;
  logic signed [MW-1:0]    mul_w;
  logic signed [C+S-1:0]   bx_r;
  logic signed [MW-1:0]    lo_r;
  logic signed [MW-1:0]    hi_r;
  logic signed [AW-1:0]    acc_r;
  logic signed [AW-1:0]    acc_nxt;
  logic signed [AW-1:0]    acc_half;
  logic signed [QW-1:0]    q_r;
  logic signed [QW-1:0]    q_nxt;
  logic signed [TW-1:0]    t;
  logic                    tfit;
  logic signed [A-1:0]     s_r;
  logic signed [A-1:0]     s_nxt;

  // y splits into an unsigned low half and a signed high half
  always_comb begin
    op_a = ctrl.mul_bx ? coef_b : coef_a;
    priority if (ctrl.mul_lo) begin
      op_b = MB'($signed({1'b0, y[H-1:0]}));
    end else if (ctrl.mul_hi) begin
      op_b = MB'($signed(y[A-1:H]));
    end else begin
      op_b = MB'(x);
    end
  end

  assign mul_w    = op_a * op_b;
  assign acc_nxt  = (AW'(hi_r) <<< H) + AW'(lo_r);
  assign acc_half = acc_r + HALF;
  assign q_nxt    = QW'(acc_half >>> F);

  assign t     = TW'(bx_r) + TW'(s_next) - TW'(q_r);
  assign tfit  = (&t[TW-1:A-1]) || (~|t[TW-1:A-1]);
  assign s_nxt = tfit ? t[A-1:0] : {t[TW-1], {(A-1){~t[TW-1]}}};

  always_ff @(posedge clk) begin
    if (ctrl.mul_bx) begin
      bx_r <= $signed(mul_w[C+S-1:0]);
    end
    if (ctrl.mul_lo) begin
      lo_r <= mul_w;
    end
    if (ctrl.mul_hi) begin
      hi_r <= mul_w;
    end
    if (ctrl.merge) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.round) begin
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (ctrl.update) begin
      s_r <= s_nxt;
    end
  end

  assign s    = s_r;
  assign clip = ~tfit;

endmodule

// File: rtl/core/iir_fourth_order_filter.sv
// Fourth-order IIR filter, transposed direct form II, top level.
// Each sample makes a seven-phase sequencer pass that reuses each section's shared
// multiplier; in_stall holds off the next sample until that pass has ended.
// Reset (rst_n, synchronous, active low) clears accumulators, coefficients and
// the handshake state. Depends on iir4_pkg, iir4_head, iir4_cell.
module iir_fourth_order_filter #(
  parameter int SAMPLE_WIDTH = iir4_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = iir4_pkg::COEF_WIDTH_DEF,
  parameter int ACCUM_WIDTH  = iir4_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]          in_sample_in,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]          out_sample_out,
  output logic                                    out_clipped,
  // configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [iir4_pkg::CFG_ADDR_WIDTH-1:0]     paddr,
  input  logic [iir4_pkg::CFG_DATA_WIDTH-1:0]     pwdata,
  output logic [iir4_pkg::CFG_DATA_WIDTH-1:0]     prdata,
  output logic                                    pready
);

  localparam int S  = SAMPLE_WIDTH;
  localparam int C  = COEF_WIDTH;
  localparam int A  = ACCUM_WIDTH;
  localparam int NS = iir4_pkg::NUM_SECTIONS;
  localparam int DW = iir4_pkg::CFG_DATA_WIDTH;

  // ---------------------------------------------------------------------
  // Coefficient registers. Pairs hold the lower-index coefficient in the
  // low field. Flattened order: b0 b1 b2 b3 b4 a1 a2 a3 a4.
  // ---------------------------------------------------------------------
  logic [2*C-1:0]         pair_r [iir4_pkg::NUM_PAIRS];
  logic [C-1:0]           a4_r;
  logic signed [C-1:0]    coef_w [iir4_pkg::NUM_COEFS];
  iir4_pkg::reg_idx_t     cfg_idx;
  logic                   cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = iir4_pkg::reg_idx_t'(paddr[iir4_pkg::CFG_ADDR_WIDTH-1:iir4_pkg::CFG_IDX_LSB]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iir4_pkg::NUM_PAIRS; i++) begin
        pair_r[i] <= '0;
      end
      a4_r <= '0;
    end else if (cfg_we) begin
      // drop writes to addresses beyond the register list
      unique case (cfg_idx)
        iir4_pkg::REG_B0_B1: pair_r[0] <= pwdata[2*C-1:0];
        iir4_pkg::REG_B2_B3: pair_r[1] <= pwdata[2*C-1:0];
        iir4_pkg::REG_B4_A1: pair_r[2] <= pwdata[2*C-1:0];
        iir4_pkg::REG_A2_A3: pair_r[3] <= pwdata[2*C-1:0];
        iir4_pkg::REG_A4:    a4_r      <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      iir4_pkg::REG_B0_B1: prdata = DW'(pair_r[0]);
      iir4_pkg::REG_B2_B3: prdata = DW'(pair_r[1]);
      iir4_pkg::REG_B4_A1: prdata = DW'(pair_r[2]);
      iir4_pkg::REG_A2_A3: prdata = DW'(pair_r[3]);
      iir4_pkg::REG_A4:    prdata = DW'(a4_r);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < iir4_pkg::NUM_PAIRS; i++) begin
      coef_w[2*i]   = $signed(pair_r[i][C-1:0]);
      coef_w[2*i+1] = $signed(pair_r[i][2*C-1:C]);
    end
    coef_w[iir4_pkg::NUM_COEFS-1] = $signed(a4_r);
  end

  // ---------------------------------------------------------------------
  // Sequencer. One sample walks through the phases:
  //   MUL_BX  every section and the head multiply their b by x
  //   CALC_Y  head forms y = b0*x + s0, saturated
  //   MUL_LO  sections multiply a by the low half of y
  //   MUL_HI  sections multiply a by the high half of y
  //   MERGE   sections combine the partial products
  //   ROUND   sections round a*y back to accumulator precision
  //   UPDATE  all accumulators load at once and the result is registered;
  //           hold here while an earlier result still waits downstream
  // ---------------------------------------------------------------------
  iir4_pkg::phase_t       state_r;
  iir4_pkg::phase_t       state_nxt;
  iir4_pkg::ctrl_t        ctrl;
  logic                   in_xfer;
  logic                   out_free;
  logic                   finish;
  logic signed [S-1:0]    x_r;

  assign in_stall = (state_r != iir4_pkg::PH_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state_r == iir4_pkg::PH_UPDATE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iir4_pkg::PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      iir4_pkg::PH_IDLE: begin
        if (in_xfer) state_nxt = iir4_pkg::PH_MUL_BX;
      end
      iir4_pkg::PH_MUL_BX: begin
        ctrl.mul_bx = 1'b1;
        state_nxt   = iir4_pkg::PH_CALC_Y;
      end
      iir4_pkg::PH_CALC_Y: begin
        ctrl.calc_y = 1'b1;
        state_nxt   = iir4_pkg::PH_MUL_LO;
      end
      iir4_pkg::PH_MUL_LO: begin
        ctrl.mul_lo = 1'b1;
        state_nxt   = iir4_pkg::PH_MUL_HI;
      end
      iir4_pkg::PH_MUL_HI: begin
        ctrl.mul_hi = 1'b1;
        state_nxt   = iir4_pkg::PH_MERGE;
      end
      iir4_pkg::PH_MERGE: begin
        ctrl.merge = 1'b1;
        state_nxt  = iir4_pkg::PH_ROUND;
      end
      iir4_pkg::PH_ROUND: begin
        ctrl.round = 1'b1;
        state_nxt  = iir4_pkg::PH_UPDATE;
      end
      iir4_pkg::PH_UPDATE: begin
        ctrl.update = out_free;
        if (out_free) state_nxt = iir4_pkg::PH_IDLE;
      end
      default: state_nxt = iir4_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= in_sample_in;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath: the head feeds y to a row of four section cells; each cell
  // takes its right neighbor's accumulator, the last one takes zero.
  // ---------------------------------------------------------------------
  logic signed [A-1:0]    y_w;
  logic                   y_clip;
  logic signed [S-1:0]    sample_w;
  logic                   sample_clip;
  logic signed [A-1:0]    s_w    [NS];
  logic signed [A-1:0]    snxt_w [NS];
  logic [NS-1:0]          cell_clip;

  iir4_head #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .ACCUM_WIDTH  (ACCUM_WIDTH)
  ) u_head (
    .clk         (clk),
    .ctrl        (ctrl),
    .x           (x_r),
    .coef_b0     (coef_w[0]),
    .s0          (s_w[0]),
    .y           (y_w),
    .y_clip      (y_clip),
    .sample      (sample_w),
    .sample_clip (sample_clip)
  );

  for (genvar k = 0; k < NS; k++) begin : g_cell
    if (k < NS - 1) begin : g_link
      assign snxt_w[k] = s_w[k+1];
    end else begin : g_tail
      assign snxt_w[k] = '0;
    end

    iir4_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH),
      .ACCUM_WIDTH  (ACCUM_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .x      (x_r),
      .y      (y_w),
      .coef_b (coef_w[k+1]),
      .coef_a (coef_w[k+NS+1]),
      .s_next (snxt_w[k]),
      .s      (s_w[k]),
      .clip   (cell_clip[k])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: parts the result channel from the sequencer.
  // ---------------------------------------------------------------------
  logic                   out_valid_r;
  logic signed [S-1:0]    out_sample_r;
  logic                   out_clipped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_sample_r  <= sample_w;
      out_clipped_r <= y_clip || sample_clip || (|cell_clip);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == iir4_pkg::PH_MUL_BX)
    else $error("input transfer did not start a pass");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iir4_pkg::PH_UPDATE) && out_valid_r && out_stall
      |=> state_r == iir4_pkg::PH_UPDATE)
    else $error("update left while the previous result was still pending");

  a_state_only_at_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != iir4_pkg::PH_UPDATE) |=> $stable(s_w[0]))
    else $error("accumulator changed outside the update phase");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == iir4_pkg::PH_UPDATE)
    else $error("result appeared without a completed pass");

endmodule
